/* sv/hsv_pkg.sv */
package hsv_pkg;

  // pipeline depth from accepted word to result strobe
  localparam int unsigned PIPE_DEPTH = 6;

  localparam logic [8:0] HUE_FULL = 9'd360;
  localparam logic [8:0] HUE_60   = 9'd60;
  localparam logic [8:0] HUE_120  = 9'd120;
  localparam logic [8:0] HUE_180  = 9'd180;
  localparam logic [8:0] HUE_240  = 9'd240;
  localparam logic [8:0] HUE_300  = 9'd300;

  // ceil(2^24 / 360) and ceil(2^20 / 60), each followed by one correction step
  localparam logic [15:0] RECIP_360 = 16'd46604;
  localparam int unsigned SHIFT_360 = 24;
  localparam logic [14:0] RECIP_60  = 15'd17477;
  localparam int unsigned SHIFT_60  = 20;

  localparam logic [7:0] VALSAT_ROUND = 8'hFF;

  typedef enum logic [2:0] {
    SEC_RED_UP,
    SEC_GREEN_DN,
    SEC_BLUE_UP,
    SEC_GREEN_UP,
    SEC_RED_DN,
    SEC_BLUE_DN
  } sector_t;

  typedef logic [15:0] pixel_t;

  function automatic pixel_t pack565(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

/* sv/hsv_to_rgb565.sv */
// hsv_to_rgb565: hsv colour to rgb565 pixel converter
//
// input channel: drive hue, sat and val with start high; the word is taken
//   at a rising edge where start is high and busy is low. busy is low at all
//   times outside reset, so one word can be taken every clock.
// output channel: pixel is valid for exactly one cycle while done is high.
//   the receiver cannot hold results off and none is needed: the pipeline
//   never stalls.
// throughput: one word per clock, set by the six-stage pipeline
//   (hue mod 360 via reciprocal multiply, chroma, sector select, slope
//   multiply, divide-by-60 via reciprocal multiply, pack)
// reset: rst is synchronous and active high. it clears the stage valid
//   bits, so no result appears after reset from words taken before it;
//   busy is high while rst is high so no word is taken during reset.
// pixel layout: red in bits 15-11, green 10-5, blue 4-0
module hsv_to_rgb565 (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [15:0]   hue,
  input  logic [7:0]    sat,
  input  logic [7:0]    val,
  output logic          done,
  output hsv_pkg::pixel_t pixel
);
  import hsv_pkg::*;

  // valid bit per stage
  logic [PIPE_DEPTH-1:0] vld;

  // stage 1: reciprocal product for hue / 360, chroma product
  logic [31:0] hq1;
  logic [15:0] hue1;
  logic [15:0] vs1;
  logic [7:0]  val1;

  // stage 2: reduced hue, chroma and floor terms
  logic [8:0]  h2;
  logic [7:0]  valsat2;
  logic [7:0]  white2;
  logic [7:0]  val2;

  // stage 3: sector and angle to the edge
  sector_t     sec3;
  logic [5:0]  angle3;
  logic [7:0]  valsat3;
  logic [7:0]  white3;
  logic [7:0]  val3;

  // stage 4: slope numerator, at most 255 * 60
  logic [13:0] num4;
  sector_t     sec4;
  logic [7:0]  white4;
  logic [7:0]  val4;

  // stage 5: reciprocal product for num / 60
  logic [28:0] nq5;
  logic [13:0] num5;
  sector_t     sec5;
  logic [7:0]  white5;
  logic [7:0]  val5;

  // combinational pieces between registers
  logic [7:0]  hq;
  logic [17:0] hrem;
  logic [8:0]  h_next;
  logic [16:0] vs_round;
  sector_t     sec_next;
  logic [8:0]  angle_next;
  logic [7:0]  sq;
  logic [13:0] sq60;
  logic [7:0]  slope;
  logic [7:0]  tint;
  logic [7:0]  r, g, b;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start};
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    hq1  <= 32'(hue) * 32'(RECIP_360);
    hue1 <= hue;
    vs1  <= 16'(val) * 16'(sat);
    val1 <= val;
  end

  // stage 2: quotient may be one too large, remainder then goes negative
  assign hq       = hq1[SHIFT_360 +: 8];
  assign hrem     = {2'b00, hue1} - ({2'b00, hq, 8'd0} + {4'd0, hq, 6'd0} +
                                     {5'd0, hq, 5'd0} + {7'd0, hq, 3'd0});
  assign h_next   = hrem[17] ? 9'(hrem[8:0] + HUE_FULL) : hrem[8:0];
  assign vs_round = {1'b0, vs1} + {9'd0, VALSAT_ROUND};

  always_ff @(posedge clk) begin
    h2      <= h_next;
    valsat2 <= vs_round[15:8];
    white2  <= val1 - vs_round[15:8];
    val2    <= val1;
  end

  // stage 3
  always_comb begin
    if (h2 < HUE_60) begin
      sec_next   = SEC_RED_UP;
      angle_next = h2;
    end else if (h2 < HUE_120) begin
      sec_next   = SEC_GREEN_DN;
      angle_next = HUE_120 - h2;
    end else if (h2 < HUE_180) begin
      sec_next   = SEC_BLUE_UP;
      angle_next = h2 - HUE_120;
    end else if (h2 < HUE_240) begin
      sec_next   = SEC_GREEN_UP;
      angle_next = HUE_240 - h2;
    end else if (h2 < HUE_300) begin
      sec_next   = SEC_RED_DN;
      angle_next = h2 - HUE_240;
    end else begin
      sec_next   = SEC_BLUE_DN;
      angle_next = HUE_FULL - h2;
    end
  end

  always_ff @(posedge clk) begin
    sec3    <= sec_next;
    angle3  <= angle_next[5:0];
    valsat3 <= valsat2;
    white3  <= white2;
    val3    <= val2;
  end

  // stage 4
  always_ff @(posedge clk) begin
    num4   <= 14'(valsat3) * 14'(angle3);
    sec4   <= sec3;
    white4 <= white3;
    val4   <= val3;
  end

  // stage 5
  always_ff @(posedge clk) begin
    nq5    <= 29'(num4) * 29'(RECIP_60);
    num5   <= num4;
    sec5   <= sec4;
    white5 <= white4;
    val5   <= val4;
  end

  // stage 6: fix an overshooting quotient, pick channels, pack
  assign sq    = nq5[SHIFT_60 +: 8];
  assign sq60  = {sq, 6'd0} - {4'd0, sq, 2'd0};
  assign slope = (sq60 > num5) ? 8'(sq - 8'd1) : sq;
  assign tint  = white5 + slope;

  always_comb begin
    case (sec5)
      SEC_RED_UP:   begin r = val5;  g = tint;  b = white5; end
      SEC_GREEN_DN: begin r = tint;  g = val5;  b = white5; end
      SEC_BLUE_UP:  begin r = white5; g = val5; b = tint;   end
      SEC_GREEN_UP: begin r = white5; g = tint; b = val5;   end
      SEC_RED_DN:   begin r = tint;  g = white5; b = val5;  end
      SEC_BLUE_DN:  begin r = val5;  g = white5; b = tint;  end
      default:      begin r = val5;  g = white5; b = white5; end
    endcase
  end

  always_ff @(posedge clk) begin
    pixel <= pack565(r, g, b);
  end

  assign done = vld[PIPE_DEPTH-1];

endmodule

/* sv/hsv_to_rgb565_chk.sv */
module hsv_to_rgb565_chk (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic [15:0]     hue,
  input logic [7:0]      sat,
  input logic [7:0]      val,
  input logic            done,
  input hsv_pkg::pixel_t pixel
);
  import hsv_pkg::*;

  // every accepted word gives a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(PIPE_DEPTH) done)
    else $error("accepted word gave no result");

  // no result without an accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without a word");

  // black in, black out
  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && val == 8'd0) |-> ##(PIPE_DEPTH) (pixel == 16'd0))
    else $error("zero value gave a lit pixel");

  // zero saturation gives grey
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && sat == 8'd0) |-> ##(PIPE_DEPTH)
      (pixel == pack565($past(val, PIPE_DEPTH), $past(val, PIPE_DEPTH),
                        $past(val, PIPE_DEPTH))))
    else $error("zero saturation gave a coloured pixel");

endmodule

bind hsv_to_rgb565 hsv_to_rgb565_chk u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .hue   (hue),
  .sat   (sat),
  .val   (val),
  .done  (done),
  .pixel (pixel)
);
